// ===== sv/ulcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ulcd_pkg;

  // Field widths of the channels.
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned OFFSET_W = 7;

  // Internal widths, sized to the ranges the arithmetic can reach.
  localparam int unsigned ERA_W   = 6;   // era index, at most 40
  localparam int unsigned YOE_W   = 9;   // year of era, 0..399
  localparam int unsigned DOY_W   = 9;   // day of shifted year, up to 397 on the way in
  localparam int unsigned DOE_W   = 18;  // day of era, 0..146096 (146128 on the way in)
  localparam int unsigned ZDAY_W  = 23;  // days since 0000-03-01, below 6.0e6
  localparam int unsigned MIN_W   = 13;  // signed minute of the UTC day after the offset
  localparam int unsigned DELTA_W = 3;   // signed day carry, -1..2
  localparam int unsigned CY_W    = 15;  // civil year before wrapping to YEAR_W
  localparam int unsigned QUAD_W  = 7;   // day of era divided by four-year days

  // Calendar constants.
  localparam int unsigned ERA_YEARS    = 400;
  localparam int unsigned CENT_YEARS   = 100;
  localparam int unsigned ERA_DAYS     = 146097;
  localparam int unsigned ERA_LAST_DAY = 146096;
  localparam int unsigned CENT_DAYS    = 36524;
  localparam int unsigned QUAD_DAYS    = 1460;
  localparam int unsigned YEAR_DAYS    = 365;
  localparam int unsigned MONTHS       = 12;
  localparam int unsigned MONTH_FEB    = 2;
  localparam int unsigned MONTH_MAR    = 3;
  localparam int unsigned MP_JAN       = 10;  // January in the March-based month index
  localparam int unsigned JAN_SHIFT    = 9;   // distance from civil to March-based January

  // Time constants.
  localparam int unsigned MIN_PER_HOUR = 60;
  localparam int unsigned MIN_PER_DAY  = 1440;
  localparam int unsigned QUARTER_MIN  = 15;
  localparam int unsigned OFFSET_BIAS  = 48;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(OFFSET_BIAS);

  // Constant divisions become a multiply by a rounded-up reciprocal and a shift.
  // Each shift K is chosen so that (largest dividend) * divisor < 2**K, which
  // makes the quotient exact without a correction step.
  localparam int unsigned DIV400_K  = 23;
  localparam int unsigned DIV400_MW = 15;
  localparam logic [63:0] DIV400_M64 =
      ((64'd1 << DIV400_K) + 64'(ERA_YEARS) - 64'd1) / 64'(ERA_YEARS);
  localparam logic [DIV400_MW-1:0] DIV400_M = DIV400_M64[DIV400_MW-1:0];

  localparam int unsigned DIVERA_K  = 41;
  localparam int unsigned DIVERA_MW = 24;
  localparam logic [63:0] DIVERA_M64 =
      ((64'd1 << DIVERA_K) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS);
  localparam logic [DIVERA_MW-1:0] DIVERA_M = DIVERA_M64[DIVERA_MW-1:0];

  localparam int unsigned DIVQUAD_K  = 29;
  localparam int unsigned DIVQUAD_MW = 19;
  localparam logic [63:0] DIVQUAD_M64 =
      ((64'd1 << DIVQUAD_K) + 64'(QUAD_DAYS) - 64'd1) / 64'(QUAD_DAYS);
  localparam logic [DIVQUAD_MW-1:0] DIVQUAD_M = DIVQUAD_M64[DIVQUAD_MW-1:0];

  localparam int unsigned DIVYEAR_K  = 27;
  localparam int unsigned DIVYEAR_MW = 19;
  localparam logic [63:0] DIVYEAR_M64 =
      ((64'd1 << DIVYEAR_K) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS);
  localparam logic [DIVYEAR_MW-1:0] DIVYEAR_M = DIVYEAR_M64[DIVYEAR_MW-1:0];

  // One reading as it enters the pipeline.
  typedef struct packed {
    logic                vld;
    logic                clock_ok;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } rtc_t;

  // Local day number handed from the forward to the inverse conversion.
  typedef struct packed {
    logic              vld;
    logic              ok;
    logic [ZDAY_W-1:0] zday;
  } zday_t;

  // Finished local date.
  typedef struct packed {
    logic               vld;
    logic               ok;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // First day of each month in a year that starts in March.
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      4'd12:   s = 9'd367;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Whole centuries in a year of era below 400.
  function automatic logic [1:0] cent_of_era(input logic [YOE_W-1:0] yoe);
    logic [1:0] c;
    c = 2'd0;
    if (yoe >= YOE_W'(CENT_YEARS)) c = 2'd1;
    if (yoe >= YOE_W'(2 * CENT_YEARS)) c = 2'd2;
    if (yoe >= YOE_W'(3 * CENT_YEARS)) c = 2'd3;
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ulcd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ulcd_cfg_if import ulcd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] utc_offset_quarters;

  modport source (output valid, output utc_offset_quarters, input ready);
  modport sink   (input valid, input utc_offset_quarters, output ready);
endinterface

interface ulcd_rtc_if import ulcd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                clock_ok;
  logic [YEAR_W-1:0]   utc_year;
  logic [MONTH_W-1:0]  utc_month;
  logic [DAY_W-1:0]    utc_day;
  logic [HOUR_W-1:0]   utc_hour;
  logic [MINUTE_W-1:0] utc_minute;

  modport source (output valid, output clock_ok, output utc_year, output utc_month,
                  output utc_day, output utc_hour, output utc_minute, input ready);
  modport sink   (input valid, input clock_ok, input utc_year, input utc_month,
                  input utc_day, input utc_hour, input utc_minute, output ready);
endinterface

interface ulcd_date_if import ulcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               date_valid;
  logic [YEAR_W-1:0]  local_year;
  logic [MONTH_W-1:0] local_month;
  logic [DAY_W-1:0]   local_day;

  modport source (output valid, output date_valid, output local_year, output local_month,
                  output local_day, input ready);
  modport sink   (input valid, input date_valid, input local_year, input local_month,
                  input local_day, output ready);
endinterface

`default_nettype wire

// ===== sv/ulcd_days_from_civil.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ulcd_days_from_civil import ulcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [OFFSET_W-1:0] offset_i,
  input  rtc_t                rtc_i,
  output zday_t               zday_o
);

  localparam int unsigned P400_W  = YEAR_W + DIV400_MW;
  localparam logic signed [MIN_W-1:0] DAY_MIN     = MIN_W'(MIN_PER_DAY);
  localparam logic signed [MIN_W-1:0] TWO_DAY_MIN = MIN_W'(2 * MIN_PER_DAY);

  // Stage A: validity, March-based month and year, minute of the local day.
  logic                a_vld_q, a_ok_q, a_ok_d, a_early;
  logic [YEAR_W-1:0]   a_yadj_q, a_yadj_d;
  logic [MONTH_W-1:0]  a_mpi_q, a_mpi_d;
  logic [DAY_W-1:0]    a_day_q;
  logic [MIN_W-1:0]    a_min_q, a_min_d;

  assign a_ok_d  = rtc_i.clock_ok && (rtc_i.year != '0) && (rtc_i.month != '0) &&
                   (rtc_i.day != '0);
  assign a_early = rtc_i.month <= MONTH_W'(MONTH_FEB);
  assign a_yadj_d = rtc_i.year - YEAR_W'(a_early);
  assign a_mpi_d  = a_early ? rtc_i.month + MONTH_W'(JAN_SHIFT)
                            : rtc_i.month - MONTH_W'(MONTH_MAR);
  assign a_min_d  = MIN_W'(int'(rtc_i.hour) * MIN_PER_HOUR + int'(rtc_i.minute) +
                           int'(offset_i) * QUARTER_MIN - OFFSET_BIAS * QUARTER_MIN);

  // Stage B: era of the year, day of year, and the day carry of the minutes.
  logic                      b_vld_q, b_ok_q;
  logic [P400_W-1:0]         b_prod;
  logic [ERA_W-1:0]          b_era_q, b_era_d;
  logic [YEAR_W-1:0]         b_yadj_q;
  logic [DOY_W-1:0]          b_doy_q, b_doy_d;
  logic signed [MIN_W-1:0]   b_min;
  logic signed [DELTA_W-1:0] b_delta_q, b_delta_d;

  assign b_prod  = P400_W'(a_yadj_q) * P400_W'(DIV400_M);
  assign b_era_d = b_prod[DIV400_K +: ERA_W];
  assign b_doy_d = month_start(a_mpi_q) + DOY_W'(a_day_q) - DOY_W'(1);
  assign b_min   = signed'(a_min_q);

  always_comb begin
    if (b_min < 0) begin
      b_delta_d = -DELTA_W'(1);
    end else if (b_min < DAY_MIN) begin
      b_delta_d = DELTA_W'(0);
    end else if (b_min < TWO_DAY_MIN) begin
      b_delta_d = DELTA_W'(1);
    end else begin
      b_delta_d = DELTA_W'(2);
    end
  end

  // Stage C: year of era and the first day of the era.
  logic                      c_vld_q, c_ok_q;
  logic [YOE_W-1:0]          c_yoe_q, c_yoe_d;
  logic [ZDAY_W-1:0]         c_zera_q, c_zera_d;
  logic [DOY_W-1:0]          c_doy_q;
  logic signed [DELTA_W-1:0] c_delta_q;

  assign c_yoe_d  = YOE_W'(b_yadj_q - YEAR_W'(b_era_q) * YEAR_W'(ERA_YEARS));
  assign c_zera_d = ZDAY_W'(b_era_q) * ZDAY_W'(ERA_DAYS);

  // Stage D: day of era.
  logic                      d_vld_q, d_ok_q;
  logic [ZDAY_W-1:0]         d_zera_q;
  logic [DOE_W-1:0]          d_doe_q, d_doe_d;
  logic signed [DELTA_W-1:0] d_delta_q;

  assign d_doe_d = DOE_W'(c_yoe_q) * DOE_W'(YEAR_DAYS) + DOE_W'(c_yoe_q >> 2) -
                   DOE_W'(cent_of_era(c_yoe_q)) + DOE_W'(c_doy_q);

  // Stage E: local day number counted from 0000-03-01.
  logic              e_vld_q, e_ok_q;
  logic [ZDAY_W-1:0] e_zday_q, e_zday_d;

  assign e_zday_d = d_zera_q + ZDAY_W'(d_doe_q) + ZDAY_W'(d_delta_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= rtc_i.vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ok_q    <= a_ok_d;
      a_yadj_q  <= a_yadj_d;
      a_mpi_q   <= a_mpi_d;
      a_day_q   <= rtc_i.day;
      a_min_q   <= a_min_d;
      b_ok_q    <= a_ok_q;
      b_era_q   <= b_era_d;
      b_yadj_q  <= a_yadj_q;
      b_doy_q   <= b_doy_d;
      b_delta_q <= b_delta_d;
      c_ok_q    <= b_ok_q;
      c_yoe_q   <= c_yoe_d;
      c_zera_q  <= c_zera_d;
      c_doy_q   <= b_doy_q;
      c_delta_q <= b_delta_q;
      d_ok_q    <= c_ok_q;
      d_zera_q  <= c_zera_q;
      d_doe_q   <= d_doe_d;
      d_delta_q <= c_delta_q;
      e_ok_q    <= d_ok_q;
      e_zday_q  <= e_zday_d;
    end
  end

  assign zday_o.vld  = e_vld_q;
  assign zday_o.ok   = e_ok_q;
  assign zday_o.zday = e_zday_q;

endmodule

`default_nettype wire

// ===== sv/ulcd_civil_from_days.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ulcd_civil_from_days import ulcd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  zday_t zday_i,
  output date_t date_o
);

  localparam int unsigned PERA_W  = ZDAY_W + DIVERA_MW;
  localparam int unsigned PQUAD_W = DOE_W + DIVQUAD_MW;
  localparam int unsigned PYEAR_W = DOE_W + DIVYEAR_MW;

  // Stage F: era of the day number.
  logic                f_vld_q, f_ok_q;
  logic [ZDAY_W-1:0]   f_zday_q;
  logic [PERA_W-1:0]   f_prod;
  logic [ERA_W-1:0]    f_era_q, f_era_d;

  assign f_prod  = PERA_W'(zday_i.zday) * PERA_W'(DIVERA_M);
  assign f_era_d = f_prod[DIVERA_K +: ERA_W];

  // Stage G: day of era.
  logic                g_vld_q, g_ok_q;
  logic [ERA_W-1:0]    g_era_q;
  logic [DOE_W-1:0]    g_doe_q, g_doe_d;

  assign g_doe_d = DOE_W'(f_zday_q - ZDAY_W'(f_era_q) * ZDAY_W'(ERA_DAYS));

  // Stage H: remove leap days so that a plain division by 365 gives the year.
  logic                h_vld_q, h_ok_q;
  logic [ERA_W-1:0]    h_era_q;
  logic [DOE_W-1:0]    h_doe_q, h_num_q, h_num_d;
  logic [PQUAD_W-1:0]  h_prod;
  logic [QUAD_W-1:0]   h_quad;
  logic [2:0]          h_cent;
  logic                h_last;

  assign h_prod = PQUAD_W'(g_doe_q) * PQUAD_W'(DIVQUAD_M);
  assign h_quad = h_prod[DIVQUAD_K +: QUAD_W];
  assign h_last = g_doe_q == DOE_W'(ERA_LAST_DAY);

  always_comb begin
    h_cent = 3'd0;
    for (int k = 1; k <= 4; k++) begin
      if (g_doe_q >= DOE_W'(k * CENT_DAYS)) begin
        h_cent = h_cent + 3'd1;
      end
    end
  end

  assign h_num_d = g_doe_q - DOE_W'(h_quad) + DOE_W'(h_cent) - DOE_W'(h_last);

  // Stage I: year of era.
  logic                i_vld_q, i_ok_q;
  logic [ERA_W-1:0]    i_era_q;
  logic [DOE_W-1:0]    i_doe_q;
  logic [PYEAR_W-1:0]  i_prod;
  logic [YOE_W-1:0]    i_yoe_q, i_yoe_d;

  assign i_prod  = PYEAR_W'(h_num_q) * PYEAR_W'(DIVYEAR_M);
  assign i_yoe_d = i_prod[DIVYEAR_K +: YOE_W];

  // Stage J: day of the March-based year and the full year.
  logic                j_vld_q, j_ok_q;
  logic [DOE_W-1:0]    j_ystart;
  logic [DOY_W-1:0]    j_doy_q, j_doy_d;
  logic [CY_W-1:0]     j_year_q, j_year_d;

  assign j_ystart = DOE_W'(i_yoe_q) * DOE_W'(YEAR_DAYS) + DOE_W'(i_yoe_q >> 2) -
                    DOE_W'(cent_of_era(i_yoe_q));
  assign j_doy_d  = DOY_W'(i_doe_q - j_ystart);
  assign j_year_d = CY_W'(i_yoe_q) + CY_W'(i_era_q) * CY_W'(ERA_YEARS);

  // Stage K: March-based month, found by comparing against the month starts.
  logic                k_vld_q, k_ok_q;
  logic [DOY_W-1:0]    k_doy_q;
  logic [CY_W-1:0]     k_year_q;
  logic [MONTH_W-1:0]  k_mp_q, k_mp_d;

  always_comb begin
    k_mp_d = '0;
    for (int k = 1; k < MONTHS; k++) begin
      if (j_doy_q >= month_start(MONTH_W'(k))) begin
        k_mp_d = k_mp_d + MONTH_W'(1);
      end
    end
  end

  // Stage L: civil month and day, year carry for January and February.
  logic                l_vld_q, l_ok_q;
  logic [MONTH_W-1:0]  l_mon;
  logic [YEAR_W-1:0]   l_year_q, l_year_d;
  logic [MONTH_W-1:0]  l_month_q, l_month_d;
  logic [DAY_W-1:0]    l_day_q, l_day_d;

  assign l_mon = (k_mp_q < MONTH_W'(MP_JAN)) ? k_mp_q + MONTH_W'(MONTH_MAR)
                                             : k_mp_q - MONTH_W'(JAN_SHIFT);

  always_comb begin
    if (k_ok_q) begin
      l_year_d  = YEAR_W'(k_year_q + CY_W'(l_mon <= MONTH_W'(MONTH_FEB)));
      l_month_d = l_mon;
      l_day_d   = DAY_W'(k_doy_q - month_start(k_mp_q) + DOY_W'(1));
    end else begin
      l_year_d  = '0;
      l_month_d = '0;
      l_day_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
      j_vld_q <= 1'b0;
      k_vld_q <= 1'b0;
      l_vld_q <= 1'b0;
    end else if (en_i) begin
      f_vld_q <= zday_i.vld;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
      j_vld_q <= i_vld_q;
      k_vld_q <= j_vld_q;
      l_vld_q <= k_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_ok_q    <= zday_i.ok;
      f_zday_q  <= zday_i.zday;
      f_era_q   <= f_era_d;
      g_ok_q    <= f_ok_q;
      g_era_q   <= f_era_q;
      g_doe_q   <= g_doe_d;
      h_ok_q    <= g_ok_q;
      h_era_q   <= g_era_q;
      h_doe_q   <= g_doe_q;
      h_num_q   <= h_num_d;
      i_ok_q    <= h_ok_q;
      i_era_q   <= h_era_q;
      i_doe_q   <= h_doe_q;
      i_yoe_q   <= i_yoe_d;
      j_ok_q    <= i_ok_q;
      j_doy_q   <= j_doy_d;
      j_year_q  <= j_year_d;
      k_ok_q    <= j_ok_q;
      k_doy_q   <= j_doy_q;
      k_year_q  <= j_year_q;
      k_mp_q    <= k_mp_d;
      l_ok_q    <= k_ok_q;
      l_year_q  <= l_year_d;
      l_month_q <= l_month_d;
      l_day_q   <= l_day_d;
    end
  end

  assign date_o.vld   = l_vld_q;
  assign date_o.ok    = l_ok_q;
  assign date_o.year  = l_year_q;
  assign date_o.month = l_month_q;
  assign date_o.day   = l_day_q;

endmodule

`default_nettype wire

// ===== sv/utc_to_local_civil_date_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UTC to local calendar date converter. Each beat on rtc_i carries one clock
// reading (success flag, UTC year, month, day, hour and minute); each beat on
// date_o carries the local calendar date for it, in the same order. A failed
// read or a zero year, month or day yields date_valid low with an all-zero
// date. Otherwise the UTC date is turned into a day number with the 400-year
// era method, the time of day plus the configured offset moves it by minus one
// to plus two days, and the day number is turned back into year, month and day.
// Out-of-range months, days, hours and minutes simply roll forward, and a year
// past 16383 wraps. The offset register (cfg_i, reset 48, meaning UTC) counts
// quarter hours with a bias of 48 and should only be written while no reading
// is in flight. The block takes one reading every clock cycle while date_o is
// not stalled; a result leaves the output register after passing through the
// twelve register stages of the pipeline (five for the forward conversion,
// seven for the inverse one). When date_o is stalled the whole pipeline holds,
// and rtc_i.ready drops in the same cycle.

module utc_to_local_civil_date_core import ulcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ulcd_cfg_if.sink    cfg_i,
  ulcd_rtc_if.sink    rtc_i,
  ulcd_date_if.source date_o
);

  // Offset register. Writes are always taken.
  logic [OFFSET_W-1:0] offset_q, offset_d;

  assign cfg_i.ready = 1'b1;
  assign offset_d    = cfg_i.valid ? cfg_i.utc_offset_quarters : offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
    end else begin
      offset_q <= offset_d;
    end
  end

  // The pipeline moves as a whole whenever the output register is empty or
  // its beat is being taken.
  logic  advance;
  rtc_t  rtc;
  zday_t zday;
  date_t date;

  assign advance     = !date.vld || date_o.ready;
  assign rtc_i.ready = advance;

  assign rtc.vld      = rtc_i.valid;
  assign rtc.clock_ok = rtc_i.clock_ok;
  assign rtc.year     = rtc_i.utc_year;
  assign rtc.month    = rtc_i.utc_month;
  assign rtc.day      = rtc_i.utc_day;
  assign rtc.hour     = rtc_i.utc_hour;
  assign rtc.minute   = rtc_i.utc_minute;

  ulcd_days_from_civil u_days (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .offset_i (offset_q),
    .rtc_i    (rtc),
    .zday_o   (zday)
  );

  ulcd_civil_from_days u_civil (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .zday_i (zday),
    .date_o (date)
  );

  assign date_o.valid       = date.vld;
  assign date_o.date_valid  = date.ok;
  assign date_o.local_year  = date.year;
  assign date_o.local_month = date.month;
  assign date_o.local_day   = date.day;

  // A stalled result must hold off new readings in the same cycle.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (date_o.valid && !date_o.ready) |-> !rtc_i.ready)
    else $error("reading accepted while the result is stalled");

  // A computed date always has a real month and a nonzero day.
  a_date_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (date_o.valid && date_o.date_valid) |->
      (date_o.local_month >= MONTH_W'(1) && date_o.local_month <= MONTH_W'(MONTHS) &&
       date_o.local_day != '0))
    else $error("computed local date out of range");

  // An invalid reading gives an all-zero date.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (date_o.valid && !date_o.date_valid) |->
      (date_o.local_year == '0 && date_o.local_month == '0 && date_o.local_day == '0))
    else $error("invalid reading produced a nonzero date");

endmodule

`default_nettype wire

// ===== dv/utc_to_local_civil_date_core_tb.sv =====
`timescale 1ns / 1ps

// Checks the UTC to local date converter against a behavioral model of the
// calendar arithmetic kept in this bench. Each accepted reading is converted
// here and queued. Every date beat that leaves the block is compared, field by
// field, with the oldest entry in that queue.

module utc_to_local_civil_date_core_tb;
  import ulcd_pkg::*;

  localparam longint DAYS_PER_ERA    = 146097;
  localparam longint DAYS_TO_EPOCH   = 719468;  // 0000-03-01 to 1970-01-01
  localparam longint MINUTES_PER_DAY = 1440;
  localparam longint OFFSET_ZERO     = 48;
  localparam int     QUIET_LIMIT     = 2000;

  typedef struct packed {
    logic                clock_ok;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } reading_t;

  typedef struct packed {
    logic               date_valid;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } local_date_t;

  logic clk_i;
  logic rst_ni;

  ulcd_cfg_if  cfg_bus ();
  ulcd_rtc_if  rtc_bus ();
  ulcd_date_if date_bus ();

  utc_to_local_civil_date_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .rtc_i  (rtc_bus),
    .date_o (date_bus)
  );

  local_date_t         pending_dates[$];
  logic [OFFSET_W-1:0] offset_setting = OFFSET_RESET;
  int                  error_count = 0;
  int                  quiet_cycles = 0;
  int                  hold_cycles = 0;
  bit                  gaps_on = 1'b1;
  bit                  stalls_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Calendar arithmetic, done in 64-bit signed integers.
  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint days_from_civil(input longint y, input longint m,
                                             input longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y -= 1;
    era = floor_quot(y, 400);
    yoe = y - era * 400;
    doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * DAYS_PER_ERA + doe - DAYS_TO_EPOCH;
  endfunction

  function automatic void civil_from_days(input longint z, output longint yr,
                                          output longint mo, output longint dy);
    longint era, doe, yoe, doy, mp;
    z += DAYS_TO_EPOCH;
    era = floor_quot(z, DAYS_PER_ERA);
    doe = z - era * DAYS_PER_ERA;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    dy  = doy - (153 * mp + 2) / 5 + 1;
    mo  = (mp < 10) ? mp + 3 : mp - 9;
    yr  = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
  endfunction

  function automatic local_date_t convert_reading(input reading_t r,
                                                  input logic [OFFSET_W-1:0] offset);
    local_date_t res;
    longint      mins, ly, lm, ld;
    res = '0;
    if (!r.clock_ok || r.year == 0 || r.month == 0 || r.day == 0) return res;
    mins = days_from_civil(longint'(r.year), longint'(r.month), longint'(r.day))
           * MINUTES_PER_DAY + longint'(r.hour) * 60 + longint'(r.minute)
           + (longint'(offset) - OFFSET_ZERO) * 15;
    civil_from_days(floor_quot(mins, MINUTES_PER_DAY), ly, lm, ld);
    res.date_valid = 1'b1;
    res.year  = ly[YEAR_W-1:0];
    res.month = lm[MONTH_W-1:0];
    res.day   = ld[DAY_W-1:0];
    return res;
  endfunction

  function automatic reading_t rtc_reading(input bit ok, input int y, input int m,
                                           input int d, input int h, input int mi);
    reading_t r;
    r.clock_ok = ok;
    r.year     = YEAR_W'(y);
    r.month    = MONTH_W'(m);
    r.day      = DAY_W'(d);
    r.hour     = HOUR_W'(h);
    r.minute   = MINUTE_W'(mi);
    return r;
  endfunction

  // Mostly sane readings, biased toward month ends and midnight so the offset
  // pushes the local date across day, month and year boundaries.
  function automatic reading_t random_reading();
    reading_t r;
    r.clock_ok = ($urandom_range(0, 15) != 0);
    case ($urandom_range(0, 9))
      0:       r.year = YEAR_W'($urandom);
      1:       r.year = YEAR_W'($urandom_range(1, 3));
      2:       r.year = YEAR_W'($urandom_range(9998, 9999));
      default: r.year = YEAR_W'($urandom_range(1, 9999));
    endcase
    case ($urandom_range(0, 9))
      0:       r.month = MONTH_W'($urandom);
      1:       r.month = MONTH_W'(($urandom_range(0, 1) == 0) ? 2 : 12);
      default: r.month = MONTH_W'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       r.day = DAY_W'($urandom_range(28, 31));
      1:       r.day = DAY_W'(1);
      default: r.day = DAY_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       r.hour = HOUR_W'($urandom);
      1, 2:    r.hour = HOUR_W'(($urandom_range(0, 1) == 0) ? 0 : 23);
      default: r.hour = HOUR_W'($urandom_range(0, 23));
    endcase
    r.minute = ($urandom_range(0, 9) == 0) ? MINUTE_W'($urandom)
                                           : MINUTE_W'($urandom_range(0, 59));
    return r;
  endfunction

  // Offers one reading from a falling edge and returns at the falling edge
  // after it was taken. Valid stays high so back-to-back beats need no gap.
  task automatic send_reading(input reading_t r);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      rtc_bus.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    rtc_bus.valid      = 1'b1;
    rtc_bus.clock_ok   = r.clock_ok;
    rtc_bus.utc_year   = r.year;
    rtc_bus.utc_month  = r.month;
    rtc_bus.utc_day    = r.day;
    rtc_bus.utc_hour   = r.hour;
    rtc_bus.utc_minute = r.minute;
    @(posedge clk_i);
    while (!rtc_bus.ready) @(posedge clk_i);
    pending_dates.push_back(convert_reading(r, offset_setting));
    @(negedge clk_i);
  endtask

  task automatic wait_for_dates();
    rtc_bus.valid = 1'b0;
    while (pending_dates.size() != 0) @(negedge clk_i);
  endtask

  // The offset may only change with nothing in flight.
  task automatic write_offset(input logic [OFFSET_W-1:0] value);
    wait_for_dates();
    cfg_bus.valid               = 1'b1;
    cfg_bus.utc_offset_quarters = value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    offset_setting = value;
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic test_directed();
    // Reset offset, which is UTC.
    send_reading(rtc_reading(1, 1970, 1, 1, 0, 0));
    send_reading(rtc_reading(0, 2024, 6, 15, 12, 30));
    send_reading(rtc_reading(1, 0, 6, 15, 12, 30));
    send_reading(rtc_reading(1, 2024, 0, 15, 12, 30));
    send_reading(rtc_reading(1, 2024, 6, 0, 12, 30));
    send_reading(rtc_reading(1, 2000, 2, 29, 23, 59));
    send_reading(rtc_reading(1, 1900, 2, 29, 0, 0));
    send_reading(rtc_reading(1, 2023, 13, 1, 0, 0));
    send_reading(rtc_reading(1, 2023, 2, 31, 24, 60));
    send_reading(rtc_reading(1, 16383, 15, 31, 31, 63));
    send_reading(rtc_reading(1, 9999, 12, 31, 23, 59));
    // Largest negative offset: the first day of year one falls into year zero.
    write_offset(OFFSET_W'(0));
    send_reading(rtc_reading(1, 1, 1, 1, 0, 0));
    send_reading(rtc_reading(1, 1970, 3, 1, 11, 59));
    send_reading(rtc_reading(1, 2024, 3, 1, 12, 0));
    // Offset of plus fourteen hours, then the raw register maximum.
    write_offset(OFFSET_W'(104));
    send_reading(rtc_reading(1, 2023, 12, 31, 10, 0));
    send_reading(rtc_reading(1, 2024, 2, 28, 9, 59));
    write_offset(OFFSET_W'(127));
    send_reading(rtc_reading(1, 9999, 12, 31, 23, 59));
    send_reading(rtc_reading(1, 16383, 12, 31, 23, 59));
    send_reading(rtc_reading(1, 16383, 15, 31, 31, 63));
    send_reading(rtc_reading(1, 2100, 2, 28, 20, 0));
    write_offset(OFFSET_W'(OFFSET_ZERO));
  endtask

  // The receiver holds off long enough for the pipeline to fill and push back
  // on the reading channel, then the sender waits for everything to drain.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    @(posedge clk_i);
    hold_cycles = 80;
    @(negedge clk_i);
    repeat (40) send_reading(random_reading());
    wait_for_dates();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    for (int i = 0; i < 590; i++) begin
      if (i > 0 && i < 490 && i % 100 == 0) begin
        write_offset(OFFSET_W'($urandom_range(0, 127)));
      end
      if (i == 490) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      send_reading(random_reading());
    end
  endtask

  initial begin
    rst_ni                      = 1'b0;
    cfg_bus.valid               = 1'b0;
    cfg_bus.utc_offset_quarters = OFFSET_RESET;
    rtc_bus.valid               = 1'b0;
    rtc_bus.clock_ok            = 1'b0;
    rtc_bus.utc_year            = '0;
    rtc_bus.utc_month           = '0;
    rtc_bus.utc_day             = '0;
    rtc_bus.utc_hour            = '0;
    rtc_bus.utc_minute          = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    wait_for_dates();
    repeat (16) @(negedge clk_i);
    if (error_count == 0 && pending_dates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus the long hold requested by a test.
  initial begin
    int stall_left;
    stall_left     = 0;
    date_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        date_bus.ready = 1'b0;
      end else if (hold_cycles > 0) begin
        date_bus.ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        date_bus.ready = 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        date_bus.ready = 1'b0;
        stall_left     = $urandom_range(0, 8);
      end else begin
        date_bus.ready = 1'b1;
      end
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : date_monitor
    local_date_t want;
    if (rst_ni && date_bus.valid && date_bus.ready) begin
      if (pending_dates.size() == 0) begin
        $error("date beat arrived with no reading outstanding");
        error_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("date_valid", 32'(want.date_valid), 32'(date_bus.date_valid));
        check_field("local_year", 32'(want.year), 32'(date_bus.local_year));
        check_field("local_month", 32'(want.month), 32'(date_bus.local_month));
        check_field("local_day", 32'(want.day), 32'(date_bus.local_day));
      end
    end
  end

  // Ends a hung run: no beat on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rtc_bus.valid && rtc_bus.ready) || (date_bus.valid && date_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// ===== sim.f =====
sv/ulcd_pkg.sv
sv/ulcd_if.sv
sv/ulcd_days_from_civil.sv
sv/ulcd_civil_from_days.sv
sv/utc_to_local_civil_date_core.sv
dv/utc_to_local_civil_date_core_tb.sv
